// ----- hdl/local_maximum_3x3_detector_assert.svh -----
// ----------------------------------------------------------------------------
// local maximum 3x3 detector assertion macros
// shared property forms for the detector's concurrent checks
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_ASSERT_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmd: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define LMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmd: next-cycle check failed");

`endif

// ----- hdl/lmd_pkg.sv -----
// ----------------------------------------------------------------------------
// lmd_pkg
// constants and types of the 3x3 local maximum detector
// ----------------------------------------------------------------------------
`default_nettype none

package lmd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 8;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MARK_W = 8;

    // configuration register widths and indexes
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_PIXELS = 2'd2;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FW_W-1:0] FW_MIN   = 11'd3;
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = 13'd3;
    localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

    // stream widths
    localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ROW_W + COL_W + MARK_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    localparam logic [MARK_W-1:0] MARK_MAX  = 8'd255;
    localparam logic [MARK_W-1:0] MARK_NONE = 8'd0;

    typedef logic [PIXEL_BITS-1:0] t_pixel;

    // item held between the line store read and the result register
    typedef struct packed {
        t_pixel             px;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               interior;
        logic               last;
    } t_stage;

endpackage

`default_nettype wire

// ----- hdl/lmd_ram.sv -----
// ----------------------------------------------------------------------------
// lmd_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/local_maximum_3x3_detector.sv -----
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector
// marks strict 3x3 local maxima of a raster-order pixel stream
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and can keep that pace indefinitely: a
// pixel is refused only while stage 1 and the output register both hold an
// item and the result side is not ready. The pixel that completes the window
// of an interior pixel is loaded into stage 1 when accepted, as the line
// stores are read; when stage 1 advances, the 3x3 compare is loaded into the
// output register, which offers the result. Only interior pixels produce a
// result, so the output carries fewer transfers than the input; border
// pixels are left for downstream to fill with 0. Each result gives row,
// column, a mark of 255 for a strict maximum (0 otherwise) and tlast on the
// last interior pixel of the frame. Frame width and height are clamped into
// 3..1024 and 3..4096 when used. The line stores are never cleared; there is
// no start-up pass after reset. Write the configuration only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "local_maximum_3x3_detector_assert.svh"

module local_maximum_3x3_detector (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write port
    input  wire                                 i_cfg_we,
    input  wire  [lmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [lmd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [lmd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] pixel
    // result stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [lmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // row, column, mark, zero pad
    output logic                                m_axis_tlast   // frame_end
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [lmd_pkg::FW_W-1:0] r_frame_width;
    logic [lmd_pkg::FH_W-1:0] r_frame_height;
    logic                     r_signed_pixels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= lmd_pkg::FW_RESET;
            r_frame_height  <= lmd_pkg::FH_RESET;
            r_signed_pixels <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lmd_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[lmd_pkg::FW_W-1:0];
                lmd_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[lmd_pkg::FH_W-1:0];
                lmd_pkg::CFG_SIGNED_PIXELS: r_signed_pixels <= i_cfg_data[0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // clamped sizes, kept as last index
    logic [lmd_pkg::FW_W-1:0]  width_clamped;
    logic [lmd_pkg::FH_W-1:0]  height_clamped;
    logic [lmd_pkg::FW_W-1:0]  width_m1_full;
    logic [lmd_pkg::FH_W-1:0]  height_m1_full;
    logic [lmd_pkg::COL_W-1:0] width_m1;
    logic [lmd_pkg::ROW_W-1:0] height_m1;

    always_comb begin
        if (r_frame_width < lmd_pkg::FW_MIN) begin
            width_clamped = lmd_pkg::FW_MIN;
        end else if (r_frame_width > lmd_pkg::FW_MAX) begin
            width_clamped = lmd_pkg::FW_MAX;
        end else begin
            width_clamped = r_frame_width;
        end
        if (r_frame_height < lmd_pkg::FH_MIN) begin
            height_clamped = lmd_pkg::FH_MIN;
        end else if (r_frame_height > lmd_pkg::FH_MAX) begin
            height_clamped = lmd_pkg::FH_MAX;
        end else begin
            height_clamped = r_frame_height;
        end
        width_m1_full  = width_clamped - lmd_pkg::FW_W'(1);
        height_m1_full = height_clamped - lmd_pkg::FH_W'(1);
        width_m1       = width_m1_full[lmd_pkg::COL_W-1:0];
        height_m1      = height_m1_full[lmd_pkg::ROW_W-1:0];
    end

    // ------------------------------------------------------------------
    // handshake: stage 1 moves on when the output register is free
    // ------------------------------------------------------------------
    lmd_pkg::t_stage r_s1;
    logic            r_s1_valid;
    logic            r_out_valid;
    logic            s1_adv;
    logic            in_xfer;

    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // stage 0: raster position of the incoming pixel
    // ------------------------------------------------------------------
    logic [lmd_pkg::COL_W-1:0] r_col_cnt;
    logic [lmd_pkg::ROW_W-1:0] r_row_cnt;
    logic [lmd_pkg::COL_W-1:0] cur_col;
    logic [lmd_pkg::ROW_W-1:0] cur_row;
    logic                      last_col;
    logic                      last_row;

    // a counter beyond a shrunken size acts as if at the last position
    assign cur_col  = (r_col_cnt > width_m1)  ? width_m1  : r_col_cnt;
    assign cur_row  = (r_row_cnt > height_m1) ? height_m1 : r_row_cnt;
    assign last_col = (cur_col == width_m1);
    assign last_row = (cur_row == height_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_xfer) begin
            if (last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= last_row ? '0 : cur_row + lmd_pkg::ROW_W'(1);
            end else begin
                r_col_cnt <= cur_col + lmd_pkg::COL_W'(1);
                r_row_cnt <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.px       <= s_axis_tdata[lmd_pkg::PIXEL_BITS-1:0];
            r_s1.col      <= cur_col;
            r_s1.row      <= cur_row;
            r_s1.interior <= (cur_row >= lmd_pkg::ROW_W'(2)) && (cur_col >= lmd_pkg::COL_W'(2));
            r_s1.last     <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // line stores: read at accept, rotate at stage 1 (upper <- middle <- pixel)
    // ------------------------------------------------------------------
    lmd_pkg::t_pixel upper_q;
    lmd_pkg::t_pixel middle_q;
    lmd_pkg::t_pixel upper_rd;
    lmd_pkg::t_pixel middle_rd;

    lmd_ram #(
        .WIDTH (lmd_pkg::PIXEL_BITS),
        .DEPTH (lmd_pkg::MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (middle_rd),
        .i_re    (in_xfer),
        .i_raddr (cur_col),
        .o_rdata (upper_q)
    );

    lmd_ram #(
        .WIDTH (lmd_pkg::PIXEL_BITS),
        .DEPTH (lmd_pkg::MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.px),
        .i_re    (in_xfer),
        .i_raddr (cur_col),
        .o_rdata (middle_q)
    );

    // the same column can be read while stage 1 writes it (size cut mid-frame);
    // the ram returns old data then, so the fresh values are forwarded
    logic            r_fwd;
    lmd_pkg::t_pixel r_fwd_upper;
    lmd_pkg::t_pixel r_fwd_middle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_xfer) begin
            r_fwd <= s1_adv && (cur_col == r_s1.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fwd_upper  <= middle_rd;
            r_fwd_middle <= r_s1.px;
        end
    end

    assign upper_rd  = r_fwd ? r_fwd_upper  : upper_q;
    assign middle_rd = r_fwd ? r_fwd_middle : middle_q;

    // ------------------------------------------------------------------
    // stage 1: window shift and strict maximum test
    // window is row major: 0..2 upper row, 3..5 middle row, 6..8 current row
    // ------------------------------------------------------------------
    lmd_pkg::t_pixel r_window [9];
    lmd_pkg::t_pixel n_window [9];
    lmd_pkg::t_pixel centre_key;
    logic            is_max;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_window[i*3]     = r_window[i*3 + 1];
            n_window[i*3 + 1] = r_window[i*3 + 2];
        end
        n_window[2] = upper_rd;
        n_window[5] = middle_rd;
        n_window[8] = r_s1.px;
    end

    // flipping the sign bit makes unsigned order match two's complement order
    always_comb begin
        lmd_pkg::t_pixel sign_flip;
        lmd_pkg::t_pixel key;
        sign_flip  = {r_signed_pixels, {(lmd_pkg::PIXEL_BITS-1){1'b0}}};
        centre_key = n_window[4] ^ sign_flip;
        is_max     = 1'b1;
        for (int i = 0; i < 9; i++) begin
            key = n_window[i] ^ sign_flip;
            if (i != 4 && !(centre_key > key)) begin
                is_max = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_window[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 9; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [lmd_pkg::ROW_W-1:0]  r_out_row;
    logic [lmd_pkg::COL_W-1:0]  r_out_col;
    logic [lmd_pkg::MARK_W-1:0] r_out_mark;
    logic                       r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1.interior;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.interior) begin
            r_out_row  <= r_s1.row - lmd_pkg::ROW_W'(1);
            r_out_col  <= r_s1.col - lmd_pkg::COL_W'(1);
            r_out_mark <= is_max ? lmd_pkg::MARK_MAX : lmd_pkg::MARK_NONE;
            r_out_last <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{lmd_pkg::OUT_PAD_W{1'b0}}, r_out_mark, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LMD_ASSERT_IMPL(a_result_is_interior, i_clk, i_rst_n, r_out_valid, (r_out_row != '0) && (r_out_col != '0) && (r_out_mark == lmd_pkg::MARK_MAX || r_out_mark == lmd_pkg::MARK_NONE))
    `LMD_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, r_s1_valid && r_out_valid && !m_axis_tready, !s_axis_tready)
    `LMD_ASSERT_NEXT(a_interior_gives_result, i_clk, i_rst_n, s1_adv && r_s1.interior, r_out_valid)
    `LMD_ASSERT_IMPL(a_result_has_source, i_clk, i_rst_n, $rose(r_out_valid), $past(s1_adv))

endmodule

`default_nettype wire
